### design/nearest_landmark_association_macros.svh
// ----------------------------------------------------------------------------
// Nearest landmark association: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH
`define NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH

// Same-cycle implication.
`define NLA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/nla_pkg.sv
// ----------------------------------------------------------------------------
// nla_pkg
// Types and constants shared by the nearest landmark association block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nla_pkg;

	localparam int DEF_MAX_LANDMARKS = 64;
	localparam int COORD_BITS        = 24;
	localparam int ID_BITS           = 16;
	localparam int MATCH_IDX_BITS    = 6;
	localparam int DIST_BITS         = 2 * COORD_BITS + 1;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]                   action;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic [ID_BITS-1:0]           landmark_id;
	} nla_cmd_t;

	typedef struct packed {
		logic                      found;
		logic [ID_BITS-1:0]        match_id;
		logic [MATCH_IDX_BITS-1:0] match_index;
		logic                      overflow;
	} nla_result_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [ID_BITS-1:0]           id;
	} nla_entry_t;

endpackage

### design/nla_ram.sv
// ----------------------------------------------------------------------------
// nla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/nla_dist.sv
// ----------------------------------------------------------------------------
// nla_dist
// Squared-distance unit: absolute differences, then squares, then their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nla_dist #(
	parameter int IDX_W = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_in,
	input  logic [IDX_W-1:0]                    idx_in,
	input  nla_pkg::nla_entry_t                 entry,
	input  logic signed [nla_pkg::COORD_BITS-1:0] obs_x,
	input  logic signed [nla_pkg::COORD_BITS-1:0] obs_y,
	output logic                                active,
	output logic                                valid_out,
	output logic [IDX_W-1:0]                    idx_out,
	output logic [nla_pkg::ID_BITS-1:0]         id_out,
	output logic [nla_pkg::DIST_BITS-1:0]       sq_dist
);

	import nla_pkg::*;

	logic signed [COORD_BITS:0]  diff_x, diff_y;
	logic [COORD_BITS:0]         mag_x, mag_y;
	logic [COORD_BITS-1:0]       dx_s2, dy_s2;
	logic [2*COORD_BITS-1:0]     sqx_s3, sqy_s3;
	logic                        v_s2, v_s3;
	logic [IDX_W-1:0]            idx_s2, idx_s3;
	logic [ID_BITS-1:0]          id_s2, id_s3;

	// Sign-extend by one bit so the difference cannot wrap.
	assign diff_x = {entry.x[COORD_BITS-1], entry.x} - {obs_x[COORD_BITS-1], obs_x};
	assign diff_y = {entry.y[COORD_BITS-1], entry.y} - {obs_y[COORD_BITS-1], obs_y};
	assign mag_x  = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : diff_x;
	assign mag_y  = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : diff_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= valid_in;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= mag_x[COORD_BITS-1:0];
		dy_s2  <= mag_y[COORD_BITS-1:0];
		idx_s2 <= idx_in;
		id_s2  <= entry.id;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		idx_s3 <= idx_s2;
		id_s3  <= id_s2;
	end

	// Any landmark still inside the unit
	assign active    = v_s2 || v_s3;
	assign valid_out = v_s3;
	assign idx_out   = idx_s3;
	assign id_out    = id_s3;
	assign sq_dist   = {1'b0, sqx_s3} + {1'b0, sqy_s3};

endmodule

### design/nearest_landmark_association.sv
// ----------------------------------------------------------------------------
// nearest_landmark_association
// Query: busy while the N stored landmarks are scanned and the pipeline drains; done pulses
// as busy falls. The scan reads one landmark per cycle from the store RAM.
// Clear and load: taken when start is accepted, no result, busy stays low.
// Reset empties the store and clears the overflow flag; RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_landmark_association_macros.svh"

module nearest_landmark_association #(
	parameter int MAX_LANDMARKS = nla_pkg::DEF_MAX_LANDMARKS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  nla_pkg::nla_cmd_t    cmd,
	output logic                 done,
	output nla_pkg::nla_result_t result
);

	import nla_pkg::*;

	localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                         state_q;
	logic [CNT_W-1:0]             count_q;
	logic                         dropped_q;
	logic [CNT_W-1:0]             rd_idx_q;
	logic                         v_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic signed [COORD_BITS-1:0] obs_x_q, obs_y_q;

	logic                         found_q;
	logic [DIST_BITS-1:0]         best_dist_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [ID_BITS-1:0]           best_id_q;

	logic                         done_q;
	nla_result_t                  result_q;

	logic                         accept, do_load, issue, scan_end, better;
	nla_entry_t                   wr_entry, rd_entry;
	logic                         d_active;
	logic                         d_valid;
	logic [IDX_W-1:0]             d_idx;
	logic [ID_BITS-1:0]           d_id;
	logic [DIST_BITS-1:0]         d_dist;
	logic [IDX_W+MATCH_IDX_BITS-1:0] idx_ext;

	assign accept  = start && !busy;
	assign do_load = accept && (cmd.action == ACT_LOAD) && (count_q < CNT_W'(MAX_LANDMARKS));
	assign issue   = (state_q == ST_SCAN) && (rd_idx_q != count_q);
	assign scan_end = (state_q == ST_SCAN) && !issue && !v_s1 && !d_active;

	assign wr_entry.x  = cmd.pos_x;
	assign wr_entry.y  = cmd.pos_y;
	assign wr_entry.id = cmd.landmark_id;

	nla_ram #(
		.WIDTH ($bits(nla_entry_t)),
		.DEPTH (MAX_LANDMARKS),
		.AW    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (do_load),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	nla_dist #(
		.IDX_W (IDX_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (v_s1),
		.idx_in    (idx_s1),
		.entry     (rd_entry),
		.obs_x     (obs_x_q),
		.obs_y     (obs_y_q),
		.active    (d_active),
		.valid_out (d_valid),
		.idx_out   (d_idx),
		.id_out    (d_id),
		.sq_dist   (d_dist)
	);

	// Skip exact hits; strict less-than keeps the first of equal candidates.
	assign better = d_valid && (d_dist != '0) && (!found_q || (d_dist < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			rd_idx_q  <= '0;
			v_s1      <= 1'b0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= scan_end;
			v_s1   <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.action)
							ACT_CLEAR: begin
								count_q   <= '0;
								dropped_q <= 1'b0;
							end
							ACT_LOAD: begin
								if (do_load) begin
									count_q <= count_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							ACT_QUERY: begin
								state_q  <= ST_SCAN;
								rd_idx_q <= '0;
								found_q  <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (better) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idx_ext = {{MATCH_IDX_BITS{1'b0}}, best_idx_q};

	always_ff @(posedge clk) begin
		if (accept && (cmd.action == ACT_QUERY)) begin
			obs_x_q <= cmd.pos_x;
			obs_y_q <= cmd.pos_y;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (better) begin
			best_dist_q <= d_dist;
			best_idx_q  <= d_idx;
			best_id_q   <= d_id;
		end
		if (scan_end) begin
			result_q.found       <= found_q;
			result_q.match_id    <= found_q ? best_id_q : '0;
			result_q.match_index <= found_q ? idx_ext[MATCH_IDX_BITS-1:0] : '0;
			result_q.overflow    <= dropped_q;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`NLA_ASSERT_NEXT(a_query_goes_busy, accept && (cmd.action == ACT_QUERY), busy, "query transfer did not start a scan")
	`NLA_ASSERT_NOW(a_done_when_idle, done_q, state_q == ST_IDLE, "result strobe outside idle")
	`NLA_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
	`NLA_ASSERT_NOW(a_pipe_in_scan, v_s1 || d_valid, state_q == ST_SCAN, "distance pipeline active while idle")
	`NLA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_LANDMARKS), "store count beyond capacity")

endmodule
